### rtl/core/onc_pkg.sv
// shared types and constants for the octahedral normal codec
// no dependencies
`default_nettype none

package onc_pkg;

	localparam int unsigned QDEPTH_DEF = 4;

	// square root: radicand is S << 16, root has half the bits
	localparam int unsigned RAD_W  = 48;
	localparam int unsigned ROOT_W = 24;

	// divider lanes
	localparam int unsigned NUM_W     = 38;
	localparam int unsigned DEN_W     = 24;
	localparam int unsigned QUO_W     = 17;
	localparam int unsigned DEC_SHIFT = 22;

	localparam logic [15:0] CODE_MID = 16'h8000;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	// classified item as held in the queue
	typedef struct packed {
		op_t                op;
		logic               zero;
		logic [17:0]        an;
		logic [17:0]        bn;
		logic [16:0]        len;
		logic signed [16:0] nx;
		logic signed [16:0] ny;
		logic signed [16:0] nz;
	} item_t;

	// sideband carried through the square root pipeline
	typedef struct packed {
		op_t         op;
		logic        zero;
		logic [17:0] an;
		logic [17:0] bn;
		logic [16:0] len;
		logic [15:0] mag_x;
		logic [15:0] mag_y;
		logic [15:0] mag_z;
		logic        neg_x;
		logic        neg_y;
		logic        neg_z;
	} rt_side_t;

	// sideband carried through the divider pipeline
	typedef struct packed {
		op_t  op;
		logic zero;
		logic rzero;
		logic neg_x;
		logic neg_y;
		logic neg_z;
	} dv_side_t;

endpackage

`default_nettype wire

### rtl/core/onc_front.sv
// front end: input register and classification of encode and decode items
// depends on onc_pkg
`default_nettype none

module onc_front import onc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               opcode,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic [15:0]        code_u,
	input  logic [15:0]        code_v,
	input  logic               q_full,
	output logic               q_wr,
	output item_t              q_item
);

	logic               vld_s1;
	op_t                op_s1;
	logic signed [15:0] x_s1, y_s1, z_s1;
	logic [15:0]        cu_s1, cv_s1;
	logic               take;

	logic [16:0]        ax, ay, az, len;
	logic signed [15:0] fx, fy;
	logic [16:0]        fxa, fya;
	logic signed [17:0] fz;
	logic [16:0]        t;

	assign full = vld_s1 && q_full;
	assign take = push && !full;
	assign q_wr = vld_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take || (vld_s1 && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= op_t'(opcode);
			x_s1  <= norm_x;
			y_s1  <= norm_y;
			z_s1  <= norm_z;
			cu_s1 <= code_u;
			cv_s1 <= code_v;
		end
	end

	// encode: L1 length and the folded numerators a+L, b+L
	always_comb begin
		ax  = x_s1[15] ? 17'(-17'(x_s1)) : 17'(x_s1);
		ay  = y_s1[15] ? 17'(-17'(y_s1)) : 17'(y_s1);
		az  = z_s1[15] ? 17'(-17'(z_s1)) : 17'(z_s1);
		len = ax + ay + az;
	end

	// decode: expand to [-1,1], rebuild z and pull x, y back by t
	always_comb begin
		fx  = signed'({~cu_s1[15], cu_s1[14:0]});
		fy  = signed'({~cv_s1[15], cv_s1[14:0]});
		fxa = fx[15] ? 17'(-17'(fx)) : 17'(fx);
		fya = fy[15] ? 17'(-17'(fy)) : 17'(fy);
		fz  = signed'(18'(19'd32768 - 19'(fxa) - 19'(fya)));
		t   = fz[17] ? 17'(-fz) : 17'd0;
	end

	always_comb begin
		q_item.op   = op_s1;
		q_item.zero = (len == 17'd0);
		q_item.len  = len;
		if (!z_s1[15]) begin
			q_item.an = 18'(19'(x_s1) + 19'(len));
			q_item.bn = 18'(19'(y_s1) + 19'(len));
		end else begin
			q_item.an = x_s1[15] ? 18'(ay) : 18'({len, 1'b0}) - 18'(ay);
			q_item.bn = y_s1[15] ? 18'(ax) : 18'({len, 1'b0}) - 18'(ax);
		end
		q_item.nx = fx[15] ? signed'(17'(18'(fx) + 18'(t))) : signed'(17'(18'(fx) - 18'(t)));
		q_item.ny = fy[15] ? signed'(17'(18'(fy) + 18'(t))) : signed'(17'(18'(fy) - 18'(t)));
		q_item.nz = signed'(17'(fz));
	end

endmodule

`default_nettype wire

### rtl/core/onc_fifo.sv
// short queue between front and back end, register storage
// depends on onc_pkg
`default_nettype none

module onc_fifo import onc_pkg::*; #(
	parameter int unsigned DEPTH = QDEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd,
	output item_t rd_item,
	output logic  empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_item = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !empty)
		else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a write");

endmodule

`default_nettype wire

### rtl/core/onc_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on onc_pkg
`default_nettype none

module onc_isqrt import onc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [RAD_W-1:0]  in_rad,
	input  rt_side_t          in_side,
	output logic              out_vld,
	output logic [ROOT_W-1:0] out_root,
	output rt_side_t          out_side
);

	logic              vld_s  [ROOT_W];
	logic [RAD_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	rt_side_t          side_s [ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_st
		localparam int unsigned K = ROOT_W - 1 - j;
		logic              pv;
		logic [RAD_W-1:0]  prem;
		logic [ROOT_W-1:0] proot;
		rt_side_t          pside;
		logic [RAD_W:0]    trial;
		logic              ge;

		if (j == 0) begin : g_first
			assign pv    = in_vld;
			assign prem  = in_rad;
			assign proot = '0;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = vld_s[j-1];
			assign prem  = rem_s[j-1];
			assign proot = root_s[j-1];
			assign pside = side_s[j-1];
		end

		// (r + 2^k)^2 - r^2 = r * 2^(k+1) + 2^(2k)
		assign trial = ((RAD_W+1)'(proot) << (K + 1)) | ((RAD_W+1)'(1) << (2 * K));
		assign ge    = (RAD_W+1)'(prem) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? prem - RAD_W'(trial) : prem;
				root_s[j] <= proot | (ROOT_W'(ge) << K);
				side_s[j] <= pside;
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W-1];
	assign out_root = root_s[ROOT_W-1];
	assign out_side = side_s[ROOT_W-1];

endmodule

`default_nettype wire

### rtl/core/onc_divider.sv
// three-lane pipelined restoring divider with a shared divisor,
// one quotient bit per stage; depends on onc_pkg
`default_nettype none

module onc_divider import onc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [2:0][NUM_W-1:0]     in_num,
	input  logic [DEN_W-1:0]          in_den,
	input  dv_side_t                  in_side,
	output logic                      out_vld,
	output logic [2:0][QUO_W-1:0]     out_quo,
	output dv_side_t                  out_side
);

	localparam int unsigned CW = DEN_W + QUO_W;

	logic                  vld_s  [QUO_W];
	logic [2:0][NUM_W-1:0] rem_s  [QUO_W];
	logic [2:0][QUO_W-1:0] quo_s  [QUO_W];
	logic [DEN_W-1:0]      den_s  [QUO_W];
	dv_side_t              side_s [QUO_W];

	for (genvar j = 0; j < QUO_W; j++) begin : g_st
		localparam int unsigned B = QUO_W - 1 - j;
		logic                  pv;
		logic [2:0][NUM_W-1:0] prem;
		logic [2:0][QUO_W-1:0] pquo;
		logic [DEN_W-1:0]      pden;
		dv_side_t              pside;
		logic [CW-1:0]         dsh;
		logic [2:0][NUM_W-1:0] nrem;
		logic [2:0][QUO_W-1:0] nquo;

		if (j == 0) begin : g_first
			assign pv    = in_vld;
			assign prem  = in_num;
			assign pquo  = '0;
			assign pden  = in_den;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = vld_s[j-1];
			assign prem  = rem_s[j-1];
			assign pquo  = quo_s[j-1];
			assign pden  = den_s[j-1];
			assign pside = side_s[j-1];
		end

		assign dsh = CW'(pden) << B;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				if (CW'(prem[l]) >= dsh) begin
					nrem[l] = prem[l] - NUM_W'(dsh);
					nquo[l] = pquo[l] | (QUO_W'(1) << B);
				end else begin
					nrem[l] = prem[l];
					nquo[l] = pquo[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= nrem;
				quo_s[j]  <= nquo;
				den_s[j]  <= pden;
				side_s[j] <= pside;
			end
		end
	end

	assign out_vld  = vld_s[QUO_W-1];
	assign out_quo  = quo_s[QUO_W-1];
	assign out_side = side_s[QUO_W-1];

endmodule

`default_nettype wire

### rtl/core/onc_back.sv
// back end: squares, square root, division and result formatting,
// ending in the output register; depends on onc_pkg, onc_isqrt, onc_divider
`default_nettype none

module onc_back import onc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  item_t       q_item,
	output logic        q_rd,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] out_u,
	output logic [15:0] out_v,
	output logic [15:0] out_x,
	output logic [15:0] out_y,
	output logic [15:0] out_z,
	output logic        zero_vector
);

	logic adv;

	logic     vld_s1, vld_s2, vld_s3, vld_s4;
	rt_side_t side_s1, side_s2, side_s3;
	rt_side_t side_in;
	logic [31:0] sqx_s2, sqy_s2, sqz_s2;
	logic [RAD_W-1:0] rad_s3;

	logic              rt_vld;
	logic [ROOT_W-1:0] rt_root;
	rt_side_t          rt_side;

	logic [2:0][NUM_W-1:0] num_s4;
	logic [DEN_W-1:0]      den_s4;
	dv_side_t              dside_s4;

	logic                  dv_vld;
	logic [2:0][QUO_W-1:0] dv_quo;
	dv_side_t              dv_side;

	logic        out_vld_q;
	logic [15:0] u_q, v_q, x_q, y_q, z_q;
	logic        zero_q;

	function automatic logic [15:0] dec_fmt(input logic [QUO_W-1:0] q, input logic neg,
		input logic rz);
		logic [15:0] mag;
		begin
			if (neg) begin
				mag = (q > QUO_W'(32768)) ? 16'h8000 : q[15:0];
				dec_fmt = rz ? 16'd0 : 16'(-mag);
			end else begin
				mag = (q > QUO_W'(32767)) ? 16'h7FFF : q[15:0];
				dec_fmt = rz ? 16'd0 : mag;
			end
		end
	endfunction

	assign adv  = !out_vld_q || pop;
	assign q_rd = adv && !q_empty;

	always_comb begin
		side_in.op    = q_item.op;
		side_in.zero  = q_item.zero;
		side_in.an    = q_item.an;
		side_in.bn    = q_item.bn;
		side_in.len   = q_item.len;
		side_in.neg_x = q_item.nx[16];
		side_in.neg_y = q_item.ny[16];
		side_in.neg_z = q_item.nz[16];
		side_in.mag_x = q_item.nx[16] ? 16'(-q_item.nx) : 16'(q_item.nx);
		side_in.mag_y = q_item.ny[16] ? 16'(-q_item.ny) : 16'(q_item.ny);
		side_in.mag_z = q_item.nz[16] ? 16'(-q_item.nz) : 16'(q_item.nz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= !q_empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
			sqx_s2  <= side_s1.mag_x * side_s1.mag_x;
			sqy_s2  <= side_s1.mag_y * side_s1.mag_y;
			sqz_s2  <= side_s1.mag_z * side_s1.mag_z;
			side_s2 <= side_s1;
			rad_s3  <= {sqx_s2 + sqy_s2 + sqz_s2, 16'd0};
			side_s3 <= side_s2;
		end
	end

	onc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s3),
		.in_rad   (rad_s3),
		.in_side  (side_s3),
		.out_vld  (rt_vld),
		.out_root (rt_root),
		.out_side (rt_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= rt_vld;
		end
	end

	// encode divides by 2L, decode by the root
	always_ff @(posedge clk) begin
		if (adv) begin
			dside_s4.op    <= rt_side.op;
			dside_s4.zero  <= rt_side.zero;
			dside_s4.rzero <= (rt_root == '0);
			dside_s4.neg_x <= rt_side.neg_x;
			dside_s4.neg_y <= rt_side.neg_y;
			dside_s4.neg_z <= rt_side.neg_z;
			if (rt_side.op == OP_ENCODE) begin
				num_s4[0] <= NUM_W'({rt_side.an, 16'd0}) + NUM_W'(rt_side.len);
				num_s4[1] <= NUM_W'({rt_side.bn, 16'd0}) + NUM_W'(rt_side.len);
				num_s4[2] <= '0;
				den_s4    <= DEN_W'({rt_side.len, 1'b0});
			end else begin
				num_s4[0] <= NUM_W'({rt_side.mag_x, DEC_SHIFT'(0)}) + NUM_W'(rt_root >> 1);
				num_s4[1] <= NUM_W'({rt_side.mag_y, DEC_SHIFT'(0)}) + NUM_W'(rt_root >> 1);
				num_s4[2] <= NUM_W'({rt_side.mag_z, DEC_SHIFT'(0)}) + NUM_W'(rt_root >> 1);
				den_s4    <= DEN_W'(rt_root);
			end
		end
	end

	onc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s4),
		.in_num   (num_s4),
		.in_den   (den_s4),
		.in_side  (dside_s4),
		.out_vld  (dv_vld),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dv_side.op == OP_ENCODE) begin
				zero_q <= dv_side.zero;
				x_q    <= '0;
				y_q    <= '0;
				z_q    <= '0;
				if (dv_side.zero) begin
					u_q <= CODE_MID;
					v_q <= CODE_MID;
				end else begin
					u_q <= dv_quo[0][16] ? 16'hFFFF : dv_quo[0][15:0];
					v_q <= dv_quo[1][16] ? 16'hFFFF : dv_quo[1][15:0];
				end
			end else begin
				zero_q <= 1'b0;
				u_q    <= '0;
				v_q    <= '0;
				x_q    <= dec_fmt(dv_quo[0], dv_side.neg_x, dv_side.rzero);
				y_q    <= dec_fmt(dv_quo[1], dv_side.neg_y, dv_side.rzero);
				z_q    <= dec_fmt(dv_quo[2], dv_side.neg_z, dv_side.rzero);
			end
		end
	end

	assign empty       = !out_vld_q;
	assign out_u       = u_q;
	assign out_v       = v_q;
	assign out_x       = x_q;
	assign out_y       = y_q;
	assign out_z       = z_q;
	assign zero_vector = zero_q;

	a_zero_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && zero_q) |-> (u_q == CODE_MID && v_q == CODE_MID && x_q == '0))
		else $error("zero vector without midpoint code");
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rt_vld && rt_side.op == OP_DECODE) |-> rt_root != '0)
		else $error("decode root is zero");
	a_dec_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_vld && dv_side.op == OP_DECODE) |->
		(!dv_quo[0][16] && !dv_quo[1][16] && !dv_quo[2][16]))
		else $error("decode quotient out of range");

endmodule

`default_nettype wire

### rtl/core/octahedral_normal_codec.sv
// Octahedral normal codec. Each item is either an encode (signed Q2.14 normal
// to a Q0.16 code pair, with a zero-vector flag) or a decode (code pair to a
// unit Q2.14 normal), chosen by opcode. Both sides look like a queue: push and
// full on input, empty and pop on output. One item is taken per cycle while
// the output is not stalled, and a result passes through the front
// register and queue, three setup stages, the 24-stage square root pipeline,
// one operand stage, the 17-stage divider and the output register. Most of
// that depth is in the square root and divider, one result bit per stage.
// A stalled output holds the whole back end; the queue of QDEPTH entries
// keeps the input side taking items meanwhile, until it fills.
// depends on onc_pkg, onc_front, onc_fifo, onc_back
`default_nettype none

module octahedral_normal_codec import onc_pkg::*; #(
	parameter int unsigned QDEPTH = QDEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               opcode,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic [15:0]        code_u,
	input  logic [15:0]        code_v,
	output logic               empty,
	input  logic               pop,
	output logic [15:0]        out_u,
	output logic [15:0]        out_v,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic               zero_vector
);

	logic  q_wr, q_full, q_rd, q_empty;
	item_t q_wr_item, q_rd_item;
	logic [15:0] x_w, y_w, z_w;

	onc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.opcode  (opcode),
		.norm_x  (norm_x),
		.norm_y  (norm_y),
		.norm_z  (norm_z),
		.code_u  (code_u),
		.code_v  (code_v),
		.q_full  (q_full),
		.q_wr    (q_wr),
		.q_item  (q_wr_item)
	);

	onc_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_item (q_wr_item),
		.full    (q_full),
		.rd      (q_rd),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	onc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (q_rd_item),
		.q_rd        (q_rd),
		.empty       (empty),
		.pop         (pop),
		.out_u       (out_u),
		.out_v       (out_v),
		.out_x       (x_w),
		.out_y       (y_w),
		.out_z       (z_w),
		.zero_vector (zero_vector)
	);

	assign out_x = signed'(x_w);
	assign out_y = signed'(y_w);
	assign out_z = signed'(z_w);

endmodule

`default_nettype wire

### bench/onc_checker.sv
// checker for the octahedral normal codec: watches both queue sides,
// predicts each result from the accepted item and compares field by field
// depends on onc_pkg
`timescale 1ns / 100ps
`default_nettype none

module onc_checker import onc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic               full,
	input  wire logic               opcode,
	input  wire logic signed [15:0] norm_x,
	input  wire logic signed [15:0] norm_y,
	input  wire logic signed [15:0] norm_z,
	input  wire logic [15:0]        code_u,
	input  wire logic [15:0]        code_v,
	input  wire logic               empty,
	input  wire logic               pop,
	input  wire logic [15:0]        out_u,
	input  wire logic [15:0]        out_v,
	input  wire logic signed [15:0] out_x,
	input  wire logic signed [15:0] out_y,
	input  wire logic signed [15:0] out_z,
	input  wire logic               zero_vector,
	output int                      errors,
	output int                      pending,
	output int                      n_results
);

	typedef struct packed {
		logic [15:0] u;
		logic [15:0] v;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic        zv;
	} codec_res_t;

	codec_res_t expected_q[$];

	function automatic longint abs_l(longint a);
		return a < 0 ? -a : a;
	endfunction

	function automatic logic [15:0] code_of(longint a, longint l);
		longint q;
		q = ((a + l) * 65536 + l) / (2 * l);
		return q > 65535 ? 16'hffff : q[15:0];
	endfunction

	function automatic longint root_of(longint n);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] unit_of(longint n, longint r);
		longint q;
		if (r == 0) return 16'd0;
		q = ((abs_l(n) <<< 22) + r / 2) / r;
		if (n < 0) begin
			if (q > 32768) q = 32768;
			q = -q;
		end else if (q > 32767) begin
			q = 32767;
		end
		return q[15:0];
	endfunction

	function automatic codec_res_t convert(op_t op, longint x, longint y, longint z,
			longint cu, longint cv);
		codec_res_t res;
		longint l, a, b, fx, fy, fz, t, nx, ny, r;
		res = '0;
		if (op == OP_ENCODE) begin
			l = abs_l(x) + abs_l(y) + abs_l(z);
			if (l == 0) begin
				res.u = CODE_MID;
				res.v = CODE_MID;
				res.zv = 1'b1;
				return res;
			end
			if (z >= 0) begin
				a = x;
				b = y;
			end else begin
				a = (x >= 0) ? l - abs_l(y) : abs_l(y) - l;
				b = (y >= 0) ? l - abs_l(x) : abs_l(x) - l;
			end
			res.u = code_of(a, l);
			res.v = code_of(b, l);
		end else begin
			fx = cu - 32768;
			fy = cv - 32768;
			fz = 32768 - abs_l(fx) - abs_l(fy);
			t = -fz;
			if (t < 0) t = 0;
			if (t > 32768) t = 32768;
			nx = fx >= 0 ? fx - t : fx + t;
			ny = fy >= 0 ? fy - t : fy + t;
			r = root_of((nx * nx + ny * ny + fz * fz) <<< 16);
			res.x = unit_of(nx, r);
			res.y = unit_of(ny, r);
			res.z = unit_of(fz, r);
		end
		return res;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %0s: got %h want %h at %0t", what, got, want, $time);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		n_results = 0;
	end

	always @(posedge clk) begin
		codec_res_t want;
		if (arst_n && push && !full)
			expected_q.push_back(convert(op_t'(opcode), norm_x, norm_y, norm_z,
				code_u, code_v));
		if (arst_n && pop && !empty) begin
			n_results++;
			if (expected_q.size() == 0) begin
				report("unexpected transaction", 16'd0, 16'd0);
			end else begin
				want = expected_q.pop_front();
				if (out_u != want.u) report("out_u", out_u, want.u);
				if (out_v != want.v) report("out_v", out_v, want.v);
				if (out_x != want.x) report("out_x", out_x, want.x);
				if (out_y != want.y) report("out_y", out_y, want.y);
				if (out_z != want.z) report("out_z", out_z, want.z);
				if (zero_vector != want.zv)
					report("zero_vector", 16'(zero_vector), 16'(want.zv));
			end
		end
		pending = expected_q.size();
	end

endmodule

`default_nettype wire

### bench/tb.sv
// testbench top for the octahedral normal codec: clock, reset, stimulus
// and verdict; checking is done by onc_checker
// depends on onc_pkg, onc_checker and the codec rtl
`timescale 1ns / 100ps
`default_nettype none

module tb import onc_pkg::*; ();

	localparam int LATENCY = 60;
	localparam int CYCLE_LIMIT = 400000;

	logic clk, arst_n, push, full, opcode, empty, pop, zero_vector;
	logic signed [15:0] norm_x, norm_y, norm_z, out_x, out_y, out_z;
	logic [15:0] code_u, code_v, out_u, out_v;
	int errors, pending, n_results, cycles;
	int send_idle, recv_idle, hold_cycles;
	int n_enc, n_dec;

	octahedral_normal_codec i_dut (.*);

	onc_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	// receiver: random stalls plus an optional long hold-off
	initial begin
		pop = 1'b0;
		hold_cycles = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic send(op_t op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic [15:0] u, logic [15:0] v);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		norm_x <= x;
		norm_y <= y;
		norm_z <= z;
		code_u <= u;
		code_v <= v;
		if (op == OP_ENCODE) n_enc++;
		else n_dec++;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic send_random();
		logic [15:0] x, y, z;
		int k;
		k = $urandom_range(9);
		x = 16'($urandom);
		y = 16'($urandom);
		z = 16'($urandom);
		// mostly unit-ish magnitudes, some with zeroed components
		if (k < 3) begin
			x = $signed(x) >>> $urandom_range(8);
			y = $signed(y) >>> $urandom_range(8);
			z = $signed(z) >>> $urandom_range(8);
		end else if (k == 3) begin
			x = 16'd0;
		end else if (k == 4) begin
			z = 16'd0;
		end
		send(op_t'($urandom_range(1)), x, y, z, 16'($urandom), 16'($urandom));
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		opcode = OP_ENCODE;
		norm_x = '0;
		norm_y = '0;
		norm_z = '0;
		code_u = '0;
		code_v = '0;
		send_idle = 0;
		recv_idle = 0;
		n_enc = 0;
		n_dec = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero vector, axes, extremes, hemisphere folds, code corners
		send(OP_ENCODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send(OP_ENCODE, 16'h4000, 16'h0000, 16'h0000, 16'hffff, 16'hffff);
		send(OP_ENCODE, 16'h0000, 16'h0000, 16'h4000, 16'h0, 16'h0);
		send(OP_ENCODE, 16'h0000, 16'h0000, 16'hc000, 16'h0, 16'h0);
		send(OP_ENCODE, 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0);
		send(OP_ENCODE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0, 16'h0);
		send(OP_ENCODE, 16'h7fff, 16'h8000, 16'h8000, 16'h0, 16'h0);
		send(OP_ENCODE, 16'h8000, 16'h7fff, 16'hffff, 16'h0, 16'h0);
		send(OP_ENCODE, 16'h0001, 16'hffff, 16'hffff, 16'h0, 16'h0);
		send(OP_ENCODE, 16'h0000, 16'h0000, 16'h0001, 16'h0, 16'h0);
		send(OP_ENCODE, 16'h0000, 16'h0000, 16'hffff, 16'h0, 16'h0);
		send(OP_ENCODE, 16'h0000, 16'h0001, 16'h0000, 16'h0, 16'h0);
		send(OP_DECODE, 16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h8000);
		send(OP_DECODE, 16'h0, 16'h0, 16'h0, 16'h0000, 16'h0000);
		send(OP_DECODE, 16'h0, 16'h0, 16'h0, 16'hffff, 16'hffff);
		send(OP_DECODE, 16'h0, 16'h0, 16'h0, 16'h0000, 16'hffff);
		send(OP_DECODE, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0000);
		send(OP_DECODE, 16'h0, 16'h0, 16'h0, 16'h8000, 16'hffff);
		send(OP_DECODE, 16'h0, 16'h0, 16'h0, 16'h0000, 16'h8000);
		send(OP_DECODE, 16'h0, 16'h0, 16'h0, 16'hc000, 16'hc000);
		send(OP_DECODE, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h8001);
		send(OP_DECODE, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h4000);
		drain();

		// random phases: free-flowing, slow sender, slow receiver, both idle
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1) ? 74 : (ph == 3) ? 7 : 0;
			recv_idle = (ph == 2) ? 74 : (ph == 3) ? 7 : 0;
			if (ph == 0) hold_cycles = 200;
			for (int i = 0; i < 150; i++) send_random();
			drain();
		end
		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < 30; i++) send_random();
		push <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		$display("%0d encodes and %0d decodes sent, %0d results checked", n_enc, n_dec,
			n_results);
		$display("directed extremes, zero vector, folds and stall phases all exercised");
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
rtl/core/onc_pkg.sv
rtl/core/onc_front.sv
rtl/core/onc_fifo.sv
rtl/core/onc_isqrt.sv
rtl/core/onc_divider.sv
rtl/core/onc_back.sv
rtl/core/octahedral_normal_codec.sv
bench/onc_checker.sv
bench/tb.sv
